// File: design/bmp24_pixel_depth_reducer_macros.svh
// Assertion macros of the bitmap depth reducer RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef BMP24_PIXEL_DEPTH_REDUCER_MACROS_SVH
`define BMP24_PIXEL_DEPTH_REDUCER_MACROS_SVH

`ifndef SYNTHESIS
// Flag any cycle out of reset in which cond holds.
`define BPDR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bpdr: forbidden condition seen");
// Flag any cycle out of reset in which ante holds and cons does not.
`define BPDR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpdr: implication violated");
`else
`define BPDR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define BPDR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/bpdr_pkg.sv
// Types, constants and the web-safe level function of the bitmap depth reducer.
// No dependencies; the interfaces and every module use it.
`timescale 1ns / 1ps
`default_nettype none

package bpdr_pkg;

  localparam int DIM_W     = 13;  // width/height register width
  localparam int POS_W     = 15;  // byte position within a padded input row
  localparam int ROW_CNT_W = 12;  // row counter within the frame
  localparam int CFG_IDX_W = 2;
  localparam int CMD_DEPTH = 2;   // command queue entries
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam int WEB_STEP  = 'h33;          // distance between web-safe levels
  localparam int WEB_HALF  = WEB_STEP / 2;  // rounding offset
  localparam int WEB_LEVELS = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_FORMAT   = 2'd2;

  // Output formats
  localparam logic FMT_WEBSAFE = 1'b0;
  localparam logic FMT_RGB555  = 1'b1;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             out_format;
  } cfg_t;

  // One pixel's worth of output work, handed from front end to back end.
  typedef struct packed {
    logic [7:0] data0;      // palette index or low byte of RGB555 word
    logic [7:0] data1;      // high byte of RGB555 word
    logic       has_word;   // second byte is data1, not padding
    logic [1:0] last_idx;   // number of bytes to emit, minus one
    logic       row_end;
    logic       frame_end;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_stat_t;

  // Nearest web-safe level (0..5) of an 8-bit channel: (c + 25) / 51.
  function automatic logic [2:0] websafe_level(input logic [7:0] c);
    logic [2:0] lvl;
    logic [8:0] sum;
    lvl = 3'd0;
    sum = {1'b0, c} + 9'(WEB_HALF);
    for (int k = 1; k <= WEB_LEVELS; k++) begin
      if (sum >= 9'(k * WEB_STEP)) lvl = lvl + 3'd1;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

// File: design/bpdr_if.sv
// Channel interfaces of the bitmap depth reducer: input bytes, output bytes, config.
// Depends on bpdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bpdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface bpdr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       row_end;
  logic       frame_end;
  modport source (output valid, output out_byte, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input row_end, input frame_end,
                  output ready);
endinterface

interface bpdr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bpdr_pkg::CFG_IDX_W-1:0]     index;
  logic [bpdr_pkg::DIM_W-1:0]         data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/bmp24_pixel_depth_reducer.sv
// Channel     | Dir | Payload                          | Transfer when
// ------------+-----+----------------------------------+------------------
// pix_in_i    | in  | in_byte[7:0]                     | valid & ready
// pix_out_o   | out | out_byte[7:0], row_end, frame_end| valid & ready
// cfg_i       | in  | index[1:0], data[12:0]           | valid & ready (always ready)
//
// Input bytes transfer one per cycle; only a red byte waits, and only while the
// two-entry command queue is full. Each pixel yields 1 (palette) or 2 (RGB555)
// output bytes, plus up to 3 zero pad bytes after a row's last pixel; the back
// end sends one byte per cycle while the sink is ready, so output bandwidth
// sets the sustained rate; a red byte passes the queue and output register.
// Reset clears counters and queue and loads width 1, height 1, palette mode.
// Either side may stall at any time; the queue and output register decouple them.
// Depends on bpdr_pkg, bpdr_if, the macros header and the three submodules.
`timescale 1ns / 1ps
`default_nettype none
`include "bmp24_pixel_depth_reducer_macros.svh"

module bmp24_pixel_depth_reducer #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  bpdr_in_if.sink     pix_in_i,
  bpdr_out_if.source  pix_out_o,
  bpdr_cfg_if.sink    cfg_i
);
  import bpdr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  fifo_stat_t fifo_stat;
  cmd_t       push_cmd, head_cmd;
  logic       push, pop;

  // Configuration registers; always ready, unknown indexes drop silently
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_i.data;
        CFG_IMAGE_HEIGHT: cfg_d.image_height = cfg_i.data;
        CFG_OUT_FORMAT:   cfg_d.out_format   = cfg_i.data[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= DIM_W'(1);
      cfg_q.image_height <= DIM_W'(1);
      cfg_q.out_format   <= FMT_WEBSAFE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: classify input bytes, build per-pixel commands
  bpdr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pix_in_i.valid),
    .in_byte_i   (pix_in_i.in_byte),
    .in_ready_o  (pix_in_i.ready),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Queue commands so front and back stall independently
  bpdr_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (fifo_stat)
  );

  // Back end: expand commands into output bytes
  bpdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (pix_out_o.valid),
    .out_ready_i (pix_out_o.ready),
    .out_byte_o  (pix_out_o.out_byte),
    .row_end_o   (pix_out_o.row_end),
    .frame_end_o (pix_out_o.frame_end)
  );

  // Front must never push into a full queue
  `BPDR_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push && fifo_stat.full)
  // Back must never pop an empty queue
  `BPDR_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop && !fifo_stat.not_empty)
  // Frame end only ever lands on a row's last byte
  `BPDR_ASSERT_IMPLY(a_frame_on_row, clk_i, rst_ni, pix_out_o.valid && pix_out_o.frame_end, pix_out_o.row_end)

endmodule

`default_nettype wire

// File: design/bpdr_front.sv
// Front end: tracks position in the padded input row, gathers B and G,
// and on each red byte builds one output command. Depends on bpdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpdr_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  bpdr_pkg::cfg_t        cfg_i,
  input  wire                   in_valid_i,
  input  wire  [7:0]            in_byte_i,
  output logic                  in_ready_o,
  input  bpdr_pkg::fifo_stat_t  fifo_stat_i,
  output logic                  push_o,
  output bpdr_pkg::cmd_t        cmd_o
);
  import bpdr_pkg::*;

  logic [POS_W-1:0]     pos_q, pos_d;
  phase_e               phase_q, phase_d;
  logic [7:0]           blue_q, blue_d, green_q, green_d;
  logic [ROW_CNT_W-1:0] row_cnt_q, row_cnt_d;

  logic [DIM_W-1:0]     w, h;
  logic [POS_W-1:0]     pix_bytes, row_len, pos_inc;
  logic [DIM_W-1:0]     row_inc;
  logic                 in_pix, is_red, accept, last_pix, frame_done;
  logic [2:0]           lvl_r, lvl_g, lvl_b;
  logic [7:0]           pal_idx;
  logic [1:0]           pad_pal;

  // Clamp dimensions into their legal range
  always_comb begin
    if (cfg_i.image_width == '0)               w = DIM_W'(1);
    else if (32'(cfg_i.image_width) > MAX_WIDTH) w = DIM_W'(MAX_WIDTH);
    else                                       w = cfg_i.image_width;
    if (cfg_i.image_height == '0)                h = DIM_W'(1);
    else if (32'(cfg_i.image_height) > MAX_HEIGHT) h = DIM_W'(MAX_HEIGHT);
    else                                         h = cfg_i.image_height;
  end

  assign pix_bytes = POS_W'({w, 1'b0}) + POS_W'(w);
  assign row_len   = pix_bytes + POS_W'(w[1:0]);
  assign pos_inc   = pos_q + POS_W'(1);
  assign in_pix    = (pos_q < pix_bytes);
  assign is_red    = in_pix && (phase_q == PH_RED);
  assign last_pix  = (pos_inc >= pix_bytes);
  assign row_inc   = {1'b0, row_cnt_q} + DIM_W'(1);
  assign frame_done = last_pix && (row_inc >= h);

  // Hold off only a red byte when the queue has no room
  assign in_ready_o = !is_red || !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && is_red;

  // Palette index r*36 + g*6 + b
  assign lvl_r   = websafe_level(in_byte_i);
  assign lvl_g   = websafe_level(green_q);
  assign lvl_b   = websafe_level(blue_q);
  assign pal_idx = 8'({lvl_r, 5'b0}) + 8'({lvl_r, 2'b0})
                 + 8'({lvl_g, 2'b0}) + 8'({lvl_g, 1'b0}) + 8'(lvl_b);
  assign pad_pal = 2'd0 - w[1:0];

  always_comb begin
    cmd_o.row_end   = last_pix;
    cmd_o.frame_end = frame_done;
    cmd_o.data1     = {1'b0, in_byte_i[7:3], green_q[7:6]};
    if (cfg_i.out_format == FMT_WEBSAFE) begin
      cmd_o.data0    = pal_idx;
      cmd_o.has_word = 1'b0;
      cmd_o.last_idx = last_pix ? pad_pal : 2'd0;
    end else begin
      cmd_o.data0    = {green_q[5:3], blue_q[7:3]};
      cmd_o.has_word = 1'b1;
      cmd_o.last_idx = (last_pix && w[0]) ? 2'd3 : 2'd1;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    phase_d   = phase_q;
    blue_d    = blue_q;
    green_d   = green_q;
    row_cnt_d = row_cnt_q;
    if (accept) begin
      if (in_pix) begin
        case (phase_q)
          PH_BLUE: begin
            blue_d  = in_byte_i;
            phase_d = PH_GREEN;
          end
          PH_GREEN: begin
            green_d = in_byte_i;
            phase_d = PH_RED;
          end
          default: begin
            phase_d = PH_BLUE;
            if (last_pix) row_cnt_d = frame_done ? '0 : row_inc[ROW_CNT_W-1:0];
          end
        endcase
      end
      // Wrap at the end of the padded input row
      if (pos_inc >= row_len) begin
        pos_d   = '0;
        phase_d = PH_BLUE;
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= PH_BLUE;
      blue_q    <= '0;
      green_q   <= '0;
      row_cnt_q <= '0;
    end else begin
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      blue_q    <= blue_d;
      green_q   <= green_d;
      row_cnt_q <= row_cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: design/bpdr_cmd_fifo.sv
// Short command queue between front end and back end.
// Depends on bpdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpdr_cmd_fifo (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  bpdr_pkg::cmd_t        cmd_i,
  input  wire                   pop_i,
  output bpdr_pkg::cmd_t        head_o,
  output bpdr_pkg::fifo_stat_t  stat_o
);
  import bpdr_pkg::*;

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.full      = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign stat_o.not_empty = (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + CMD_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + CMD_PTR_W'(1);
    end
    if (push_i && !pop_i)      cnt_d = cnt_q + CMD_CNT_W'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CMD_CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: design/bpdr_back.sv
// Back end: expands the queue head into output bytes, one per cycle while the
// output is ready, through a registered output stage. Depends on bpdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpdr_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  bpdr_pkg::fifo_stat_t  fifo_stat_i,
  input  bpdr_pkg::cmd_t        head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  row_end_o,
  output logic                  frame_end_o
);
  import bpdr_pkg::*;

  logic [1:0] k_q, k_d;
  logic       ov_q, ov_d;
  logic [7:0] byte_q, byte_d;
  logic       re_q, re_d, fe_q, fe_d;
  logic       load, at_last;

  assign load    = fifo_stat_i.not_empty && (!ov_q || out_ready_i);
  assign at_last = (k_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  always_comb begin
    k_d    = k_q;
    ov_d   = ov_q;
    byte_d = byte_q;
    re_d   = re_q;
    fe_d   = fe_q;
    if (load) begin
      ov_d = 1'b1;
      if (k_q == 2'd0)                        byte_d = head_i.data0;
      else if (k_q == 2'd1 && head_i.has_word) byte_d = head_i.data1;
      else                                    byte_d = 8'd0;
      re_d = at_last && head_i.row_end;
      fe_d = at_last && head_i.frame_end;
      k_d  = at_last ? 2'd0 : k_q + 2'd1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    re_q   <= re_d;
    fe_q   <= fe_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      k_q  <= k_d;
      ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign row_end_o   = re_q;
  assign frame_end_o = fe_q;

endmodule

`default_nettype wire
